// ----- rtl/ssc_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssc_pkg - shared types and constants of the servo s-curve ramp
// Field widths, default parameter values, function codes and the words
// passed between the ramp modules.
// -----------------------------------------------------------------------------
package ssc_pkg;

   // default sizes
   localparam int SAMPLES_DEF  = 150;
   localparam int CHANNELS_DEF = 10;

   // fixed field widths
   localparam int CHAN_W    = 4;
   localparam int PULSE_W   = 16;
   localparam int TPS_W     = 8;
   localparam int IDX_W     = 8;
   localparam int HALF_W    = 17;
   localparam int SHAPE_W   = 16;
   localparam int FRAC_BITS = 14;

   // reset values
   localparam logic [PULSE_W-1:0] RESET_POS = 16'd1500;
   localparam logic [TPS_W-1:0]   TPS_RESET = 8'd1;

   // function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // operands of one profile sample
   typedef struct packed {
      logic        [PULSE_W-1:0] start_point;
      logic signed [HALF_W-1:0]  half_step;
   } sample_op_type;

   // per-item status from the channel logic
   typedef struct packed {
      logic updated;
      logic finished;
      logic busy_res;
   } chan_status_type;

   // one result word
   typedef struct packed {
      logic [CHAN_W-1:0]  out_channel;
      logic [PULSE_W-1:0] pulse;
      logic               updated;
      logic               finished;
      logic               busy_res;
   } rsp_word_type;

endpackage

// ----- rtl/ssc_req_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssc_req_if - request channel of the servo s-curve ramp
// Valid/ready channel carrying one start or tick word.
// -----------------------------------------------------------------------------
interface ssc_req_if import ssc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               func;
   logic [CHAN_W-1:0]  channel;
   logic [PULSE_W-1:0] target;

   modport source (output valid, func, channel, target, input ready);
   modport sink   (input valid, func, channel, target, output ready);
endinterface

// ----- rtl/ssc_rsp_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssc_rsp_if - response channel of the servo s-curve ramp
// Valid/ready channel carrying one result word per request word.
// -----------------------------------------------------------------------------
interface ssc_rsp_if import ssc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  out_channel;
   logic [PULSE_W-1:0] pulse;
   logic               updated;
   logic               finished;
   logic               busy_res;

   modport source (output valid, out_channel, pulse, updated, finished, busy_res,
                   input ready);
   modport sink   (input valid, out_channel, pulse, updated, finished, busy_res,
                   output ready);
endinterface

// ----- rtl/ssc_csr_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssc_csr_if - configuration write channel of the servo s-curve ramp
// Valid/ready channel carrying the ticks_per_sample register value.
// -----------------------------------------------------------------------------
interface ssc_csr_if import ssc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [TPS_W-1:0] ticks_per_sample;

   modport source (output valid, ticks_per_sample, input ready);
   modport sink   (input valid, ticks_per_sample, output ready);
endinterface

// ----- rtl/ssc_shape_rom.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssc_shape_rom - exponential s-curve profile table
// SAMPLES+1 points in unsigned Q2.14, built at elaboration from a Q32
// Taylor series of e^x, read combinationally at one index.
// -----------------------------------------------------------------------------
module ssc_shape_rom import ssc_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic [IDX_W-1:0]   idx,
   output logic [SHAPE_W-1:0] shape
);

   localparam int ROM_AW = $clog2(SAMPLES + 1);
   localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

   // q32 product, truncated
   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[95:32];
   endfunction

   // e^t in q32, 25-term taylor sum with truncated terms
   function automatic logic [63:0] exp_q32(input logic [63:0] t);
      logic [63:0] term;
      logic [63:0] sum;
      term = Q32_ONE;
      sum  = Q32_ONE;
      term = mul_q32(term, t) / 64'd1;  sum = sum + term;
      term = mul_q32(term, t) / 64'd2;  sum = sum + term;
      term = mul_q32(term, t) / 64'd3;  sum = sum + term;
      term = mul_q32(term, t) / 64'd4;  sum = sum + term;
      term = mul_q32(term, t) / 64'd5;  sum = sum + term;
      term = mul_q32(term, t) / 64'd6;  sum = sum + term;
      term = mul_q32(term, t) / 64'd7;  sum = sum + term;
      term = mul_q32(term, t) / 64'd8;  sum = sum + term;
      term = mul_q32(term, t) / 64'd9;  sum = sum + term;
      term = mul_q32(term, t) / 64'd10; sum = sum + term;
      term = mul_q32(term, t) / 64'd11; sum = sum + term;
      term = mul_q32(term, t) / 64'd12; sum = sum + term;
      term = mul_q32(term, t) / 64'd13; sum = sum + term;
      term = mul_q32(term, t) / 64'd14; sum = sum + term;
      term = mul_q32(term, t) / 64'd15; sum = sum + term;
      term = mul_q32(term, t) / 64'd16; sum = sum + term;
      term = mul_q32(term, t) / 64'd17; sum = sum + term;
      term = mul_q32(term, t) / 64'd18; sum = sum + term;
      term = mul_q32(term, t) / 64'd19; sum = sum + term;
      term = mul_q32(term, t) / 64'd20; sum = sum + term;
      term = mul_q32(term, t) / 64'd21; sum = sum + term;
      term = mul_q32(term, t) / 64'd22; sum = sum + term;
      term = mul_q32(term, t) / 64'd23; sum = sum + term;
      term = mul_q32(term, t) / 64'd24; sum = sum + term;
      return sum;
   endfunction

   logic [SHAPE_W-1:0] rom [SAMPLES+1];

   // x = 1.4*k/SAMPLES, k = min(i, SAMPLES-i); rising half e^x - 1, falling 3 - e^x
   for (genvar i = 0; i <= SAMPLES; i++) begin : g_pt
      localparam bit          RISE = (2 * i <= SAMPLES);
      localparam int          K    = RISE ? i : SAMPLES - i;
      localparam logic [63:0] T    = (64'(K) * 64'd7 * Q32_ONE + 64'((5 * SAMPLES) / 2))
                                     / 64'(5 * SAMPLES);
      localparam logic [63:0] EV   = exp_q32(T);
      localparam logic [63:0] V    = RISE ? (EV - Q32_ONE) : (64'd3 * Q32_ONE - EV);
      localparam logic [63:0] R    = (V + 64'h2_0000) >> 18;
      assign rom[i] = R[SHAPE_W-1:0];
   end

   // read, index held to the last point
   logic [IDX_W-1:0] idx_c;
   assign idx_c = (idx > IDX_W'(SAMPLES)) ? IDX_W'(SAMPLES) : idx;
   assign shape = rom[idx_c[ROM_AW-1:0]];

endmodule

// ----- rtl/ssc_sample_calc.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssc_sample_calc - profile sample arithmetic
// floor((start*2^14 + half_step*shape) / 2^14), clamped to 0..65535.
// -----------------------------------------------------------------------------
module ssc_sample_calc import ssc_pkg::*; (
   input  sample_op_type      op,
   input  logic [SHAPE_W-1:0] shape,
   output logic [PULSE_W-1:0] pulse
);

   localparam int PROD_W = HALF_W + SHAPE_W + 1;
   localparam int NUM_W  = PROD_W + 2;
   localparam int Q_W    = NUM_W - FRAC_BITS;

   logic signed [PROD_W-1:0] prod;
   logic signed [NUM_W-1:0]  base;
   logic signed [NUM_W-1:0]  num;
   logic signed [Q_W-1:0]    q;

   // multiply-add in q2.14
   assign prod = op.half_step * $signed({1'b0, shape});
   assign base = $signed({{(NUM_W-PULSE_W-FRAC_BITS){1'b0}}, op.start_point,
                          {FRAC_BITS{1'b0}}});
   assign num  = base + NUM_W'(prod);

   // floor division by 2^14 is the upper bits
   assign q = num[NUM_W-1:FRAC_BITS];

   // clamp to 16 bits unsigned
   always_comb begin
      if (q[Q_W-1]) begin
         pulse = '0;
      end else if (q[Q_W-2:PULSE_W] != '0) begin
         pulse = '1;
      end else begin
         pulse = q[PULSE_W-1:0];
      end
   end

endmodule

// ----- rtl/ssc_chan_ctrl.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssc_chan_ctrl - per-channel ramp state
// Holds position, start point, half step, sample index, divider and the
// moving flag of every channel, and applies one start or tick word.
// -----------------------------------------------------------------------------
module ssc_chan_ctrl import ssc_pkg::*; #(
   parameter int SAMPLES  = SAMPLES_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               func,
   input  logic [CHAN_W-1:0]  channel,
   input  logic [PULSE_W-1:0] target,
   input  logic [TPS_W-1:0]   tps,
   output sample_op_type      op,
   output logic [IDX_W-1:0]   rom_idx,
   output chan_status_type    status
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic        [PULSE_W-1:0] position_ff    [CHANNELS];
   logic        [PULSE_W-1:0] start_point_ff [CHANNELS];
   logic signed [HALF_W-1:0]  half_step_ff   [CHANNELS];
   logic        [IDX_W-1:0]   sample_idx_ff  [CHANNELS];
   logic        [TPS_W-1:0]   divider_ff     [CHANNELS];
   logic                      moving_ff      [CHANNELS];

   logic        [PULSE_W-1:0] position_in;
   logic        [PULSE_W-1:0] start_point_in;
   logic signed [HALF_W-1:0]  half_step_in;
   logic        [IDX_W-1:0]   sample_idx_in;
   logic        [TPS_W-1:0]   divider_in;
   logic                      moving_in;

   logic                      ch_ok;
   logic        [CH_W-1:0]    sel;
   logic signed [HALF_W-1:0]  diff;
   logic        [HALF_W:0]    diff_adj;
   logic        [TPS_W-1:0]   div_inc;
   logic                      hit;
   logic                      last;

   assign ch_ok = ({1'b0, channel} < (CHAN_W+1)'(CHANNELS));
   assign sel   = channel[CH_W-1:0];

   // sample operands of the addressed channel
   assign op.start_point = start_point_ff[sel];
   assign op.half_step   = half_step_ff[sel];
   assign rom_idx        = sample_idx_ff[sel];

   // half step, truncated toward zero
   assign diff     = $signed({1'b0, target}) - $signed({1'b0, position_ff[sel]});
   assign diff_adj = {diff[HALF_W-1], diff} + {{HALF_W{1'b0}}, diff[HALF_W-1]};

   // divider and end of sweep
   assign div_inc = divider_ff[sel] + TPS_W'(1);
   assign hit     = (div_inc == tps);
   assign last    = (sample_idx_ff[sel] == IDX_W'(SAMPLES));

   // next state of the addressed channel
   always_comb begin
      position_in    = position_ff[sel];
      start_point_in = start_point_ff[sel];
      half_step_in   = half_step_ff[sel];
      sample_idx_in  = sample_idx_ff[sel];
      divider_in     = divider_ff[sel];
      moving_in      = moving_ff[sel];
      status         = '0;
      if (ch_ok) begin
         if (func == FUNC_START) begin
            start_point_in = position_ff[sel];
            half_step_in   = diff_adj[HALF_W:1];
            position_in    = target;
            sample_idx_in  = '0;
            divider_in     = '0;
            moving_in      = 1'b1;
         end else if (moving_ff[sel]) begin
            if (hit) begin
               divider_in     = '0;
               status.updated = 1'b1;
               if (last) begin
                  sample_idx_in   = '0;
                  moving_in       = 1'b0;
                  status.finished = 1'b1;
               end else begin
                  sample_idx_in = sample_idx_ff[sel] + IDX_W'(1);
               end
            end else begin
               divider_in = div_inc;
            end
         end
         status.busy_res = moving_in;
      end
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            position_ff[c]    <= RESET_POS;
            start_point_ff[c] <= RESET_POS;
            half_step_ff[c]   <= '0;
            sample_idx_ff[c]  <= '0;
            divider_ff[c]     <= '0;
            moving_ff[c]      <= 1'b0;
         end
      end else if (fire && ch_ok) begin
         position_ff[sel]    <= position_in;
         start_point_ff[sel] <= start_point_in;
         half_step_ff[sel]   <= half_step_in;
         sample_idx_ff[sel]  <= sample_idx_in;
         divider_ff[sel]     <= divider_in;
         moving_ff[sel]      <= moving_in;
      end
   end

endmodule

// ----- rtl/servo_s_curve_ramp_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// servo_s_curve_ramp_top - multi-channel servo pulse ramp with s-curve profile
// A start word sets a channel's target; tick words step the channel through
// an exponential s-curve and emit compare values.
// -----------------------------------------------------------------------------
// Every request word gives exactly one response word. The block takes one word
// per clock when the response side keeps up: a word sits in the input register,
// then the channel state update, the profile table lookup and one 17x17
// multiply-add with clamp run in a single pass into the response register, and
// the multiply-add path sets the clock rate. While a response waits unaccepted,
// the word behind it holds in the input register and one more word can enter
// only if that register is empty. ticks_per_sample is written over the csr
// channel (always ready); the user must write it only while no word is in
// flight, as the block does not enforce this. A value of zero gives one sample
// every 256 ticks. There is no clearing pass after reset.
module servo_s_curve_ramp_top import ssc_pkg::*; #(
   parameter int SAMPLES  = SAMPLES_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ssc_req_if.sink   req_in,
   ssc_rsp_if.source rsp_out,
   ssc_csr_if.sink   csr_in
);

   logic               s1_valid_ff;
   logic               s1_func_ff;
   logic [CHAN_W-1:0]  s1_channel_ff;
   logic [PULSE_W-1:0] s1_target_ff;
   logic [TPS_W-1:0]   tps_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;
   rsp_word_type       rsp_in;

   logic               advance;
   logic               take;
   sample_op_type      op;
   logic [IDX_W-1:0]   rom_idx;
   logic [SHAPE_W-1:0] shape;
   logic [PULSE_W-1:0] sample;
   chan_status_type    status;

   // handshake
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_out.ready);
   assign req_in.ready = !s1_valid_ff || advance;
   assign take         = req_in.valid && req_in.ready;
   assign csr_in.ready = 1'b1;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else if (csr_in.valid) begin
         tps_ff <= csr_in.ticks_per_sample;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_func_ff    <= req_in.func;
         s1_channel_ff <= req_in.channel;
         s1_target_ff  <= req_in.target;
      end
   end

   // channel state
   ssc_chan_ctrl #(
      .SAMPLES  (SAMPLES),
      .CHANNELS (CHANNELS)
   ) u_chan (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .func    (s1_func_ff),
      .channel (s1_channel_ff),
      .target  (s1_target_ff),
      .tps     (tps_ff),
      .op      (op),
      .rom_idx (rom_idx),
      .status  (status)
   );

   // profile table
   ssc_shape_rom #(
      .SAMPLES (SAMPLES)
   ) u_rom (
      .idx   (rom_idx),
      .shape (shape)
   );

   // sample arithmetic
   ssc_sample_calc u_calc (
      .op    (op),
      .shape (shape),
      .pulse (sample)
   );

   // response word
   always_comb begin
      rsp_in.out_channel = s1_channel_ff;
      rsp_in.pulse       = status.updated ? sample : '0;
      rsp_in.updated     = status.updated;
      rsp_in.finished    = status.finished;
      rsp_in.busy_res    = status.busy_res;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_out.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_out.valid       = rsp_valid_ff;
   assign rsp_out.out_channel = rsp_ff.out_channel;
   assign rsp_out.pulse       = rsp_ff.pulse;
   assign rsp_out.updated     = rsp_ff.updated;
   assign rsp_out.finished    = rsp_ff.finished;
   assign rsp_out.busy_res    = rsp_ff.busy_res;

endmodule
